// File: rtl/core/base64_stream_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// base64_stream_decoder_core_assert.svh
// Assertion macros shared by the decoder core.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_CORE_ASSERT_SVH
`define BASE64_STREAM_DECODER_CORE_ASSERT_SVH

// Implication in the same cycle.
`define B64SD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication in the next cycle.
`define B64SD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/b64sd_pkg.sv
// ----------------------------------------------------------------------------
// b64sd_pkg
// Types, constants and the alphabet decode for the base64 stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64sd_pkg;

   localparam int QDEPTH = 4;
   localparam int QAW    = 2;
   localparam int QCW    = 3;

   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UZ    = 8'h5A;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LZ    = 8'h7A;
   localparam logic [7:0] CHAR_D0    = 8'h30;
   localparam logic [7:0] CHAR_D9    = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam logic [1:0] IDX_FIRST  = 2'd0;
   localparam logic [1:0] IDX_SECOND = 2'd1;
   localparam logic [1:0] IDX_THIRD  = 2'd2;

   typedef struct packed {
      logic [7:0] encoded_char;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] decoded_byte;
      logic       byte_present;
      logic       message_end;
   } rsp_type;

   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  last_idx;
      logic        end_flag;
      logic        present;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // {valid, sextet}
   function automatic logic [6:0] sextet_of(logic [7:0] c);
      logic [7:0] d;
      logic [6:0] r;
      d = 8'd0;
      r = 7'd0;
      if (c >= CHAR_UA && c <= CHAR_UZ) begin
         d = c - CHAR_UA;
         r = {1'b1, d[5:0]};
      end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
         d = c - CHAR_LA + 8'd26;
         r = {1'b1, d[5:0]};
      end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
         d = c - CHAR_D0 + 8'd52;
         r = {1'b1, d[5:0]};
      end else if (c == CHAR_PLUS) begin
         r = {1'b1, 6'd62};
      end else if (c == CHAR_SLASH) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

endpackage

// File: rtl/core/b64sd_front.sv
// ----------------------------------------------------------------------------
// b64sd_front
// Classifies characters, collects sextets and issues byte jobs to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64sd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  b64sd_pkg::req_type  req_data,
   input  logic                q_full,
   output b64sd_pkg::push_type push_out
);

   logic [17:0] grp_ff, grp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        stop_ff, stop_in;
   logic        accept;
   logic [6:0]  sx;
   logic        emit;
   b64sd_pkg::job_type job;

   assign accept = req_valid && !q_full;
   assign sx     = b64sd_pkg::sextet_of(req_data.encoded_char);

   always_comb begin
      grp_in  = grp_ff;
      cnt_in  = cnt_ff;
      stop_in = stop_ff;
      emit    = 1'b0;
      job     = '0;
      if (!stop_ff) begin
         if (!sx[6]) begin
            stop_in = 1'b1;
         end else if (cnt_ff == 2'd3) begin
            emit         = 1'b1;
            job.word     = {grp_ff, sx[5:0]};
            job.last_idx = b64sd_pkg::IDX_THIRD;
            job.end_flag = req_data.last_char;
            job.present  = 1'b1;
            grp_in       = '0;
            cnt_in       = 2'd0;
         end else begin
            grp_in = {grp_ff[11:0], sx[5:0]};
            cnt_in = cnt_ff + 2'd1;
         end
      end
      if (req_data.last_char) begin
         if (!emit) begin
            emit         = 1'b1;
            job.end_flag = 1'b1;
            case (cnt_in)
               2'd2: begin
                  job.word     = {grp_in[11:0], 12'd0};
                  job.last_idx = b64sd_pkg::IDX_FIRST;
                  job.present  = 1'b1;
               end
               2'd3: begin
                  job.word     = {grp_in, 6'd0};
                  job.last_idx = b64sd_pkg::IDX_SECOND;
                  job.present  = 1'b1;
               end
               default: begin
                  job.word     = '0;
                  job.last_idx = b64sd_pkg::IDX_FIRST;
                  job.present  = 1'b0;
               end
            endcase
         end
         grp_in  = '0;
         cnt_in  = 2'd0;
         stop_in = 1'b0;
      end
   end

   assign push_out.push = accept && emit;
   assign push_out.job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff  <= '0;
         cnt_ff  <= 2'd0;
         stop_ff <= 1'b0;
      end else if (accept) begin
         grp_ff  <= grp_in;
         cnt_ff  <= cnt_in;
         stop_ff <= stop_in;
      end
   end

endmodule

// File: rtl/core/b64sd_queue.sv
// ----------------------------------------------------------------------------
// b64sd_queue
// Small job queue between the classifier and the byte serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64sd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  b64sd_pkg::push_type  push_in,
   input  logic                 pop,
   output b64sd_pkg::job_type   head,
   output b64sd_pkg::qstat_type stat
);

   b64sd_pkg::job_type         mem_ff [b64sd_pkg::QDEPTH];
   logic [b64sd_pkg::QAW-1:0]  wr_ff, wr_in;
   logic [b64sd_pkg::QAW-1:0]  rd_ff, rd_in;
   logic [b64sd_pkg::QCW-1:0]  lvl_ff, lvl_in;
   logic                       do_push, do_pop;

   assign stat.full  = (lvl_ff == b64sd_pkg::QCW'(b64sd_pkg::QDEPTH));
   assign stat.empty = (lvl_ff == '0);
   assign do_push    = push_in.push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop  ? rd_ff + 1'b1 : rd_ff;
      lvl_in = lvl_ff;
      if (do_push && !do_pop) begin
         lvl_in = lvl_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         lvl_in = lvl_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_in.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         lvl_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         lvl_ff <= lvl_in;
      end
   end

endmodule

// File: rtl/core/b64sd_back.sv
// ----------------------------------------------------------------------------
// b64sd_back
// Serializes queued jobs into one result transaction per cycle unless rsp_stall holds the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64sd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  b64sd_pkg::job_type   head,
   input  b64sd_pkg::qstat_type stat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output b64sd_pkg::rsp_type   rsp_data
);

   logic               rsp_valid_ff, rsp_valid_in;
   b64sd_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [1:0]         idx_ff, idx_in;
   logic               load, take, at_last;
   logic [7:0]         sel_byte;

   assign load    = !rsp_valid_ff || !rsp_stall;
   assign take    = load && !stat.empty;
   assign at_last = (idx_ff == head.last_idx);
   assign pop     = take && at_last;

   always_comb begin
      case (idx_ff)
         b64sd_pkg::IDX_FIRST:  sel_byte = head.word[23:16];
         b64sd_pkg::IDX_SECOND: sel_byte = head.word[15:8];
         default:               sel_byte = head.word[7:0];
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in             = !stat.empty;
         rsp_data_in.decoded_byte = sel_byte;
         rsp_data_in.byte_present = head.present;
         rsp_data_in.message_end  = head.end_flag && at_last;
      end
      if (take) begin
         idx_in = at_last ? b64sd_pkg::IDX_FIRST : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= b64sd_pkg::IDX_FIRST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/base64_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: characters in, decoded bytes out.
// ----------------------------------------------------------------------------
// The core accepts one encoded character per cycle while req_stall is low;
// each character that completes a group of four, and each final character,
// places one job of one to three result transactions in a four-entry queue;
// the output serializer delivers one result per cycle unless rsp_stall is
// set, so four characters that yield three bytes keep the stream at full
// rate. A job's first result is registered in the queue, then in rsp_data_ff.
// req_stall rises only while the queue is full, when the result side stalls.
`timescale 1ns / 1ps
`include "base64_stream_decoder_core_assert.svh"

module base64_stream_decoder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  b64sd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output b64sd_pkg::rsp_type rsp_data
);

   b64sd_pkg::push_type  push;
   b64sd_pkg::job_type   head;
   b64sd_pkg::qstat_type stat;
   logic                 pop;

   assign req_stall = stat.full;

   b64sd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (stat.full),
      .push_out  (push)
   );

   b64sd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .head    (head),
      .stat    (stat)
   );

   b64sd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .stat      (stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `B64SD_ASSERT_IMP(a_no_push_full, clock, reset, push.push, !stat.full)
   `B64SD_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, !stat.empty)
   `B64SD_ASSERT_IMP(a_empty_is_end, clock, reset, rsp_valid && !rsp_data.byte_present, rsp_data.message_end)
   `B64SD_ASSERT_NXT(a_queue_drains, clock, reset, !stat.empty && !rsp_stall, rsp_valid)

endmodule
